>>> rtl/core/ftstat_pkg.sv
// shared types and constants of the frame time statistics block
package ftstat_pkg;

  localparam int unsigned MS_W   = 10;
  localparam int unsigned IN_MSW = 16;

  localparam logic [MS_W-1:0] MS_MAX = MS_W'(1000);
  localparam logic [MS_W-1:0] MS_MIN = MS_W'(1);

  localparam logic [1:0] KIND_RECORD = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [IN_MSW-1:0] frame_ms;
  } ftstat_in_t;

  typedef struct packed {
    logic [MS_W-1:0] avg_rate;
    logic [MS_W-1:0] best_gain;
    logic [MS_W-1:0] worst_loss;
    logic [MS_W-1:0] latest_ms;
  } ftstat_out_t;

endpackage

>>> rtl/core/ftstat_ram.sv
// generic single write port ram with registered read
module ftstat_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 60
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/ftstat_div.sv
// restoring divider, one quotient bit per cycle
module ftstat_div #(
  parameter int unsigned W = 18
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic [W:0]    shifted;
  logic          fits;

  assign shifted = {rem_q, quo_q[W-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CW'(W);
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (run_q) begin
      rem_d = fits ? W'(shifted - {1'b0, dvs_q}) : shifted[W-1:0];
      quo_d = {quo_q[W-2:0], fits};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> rtl/core/frame_time_statistics_core.sv
// frame time statistics core: ring of frame times with windowed rate query
// record writes the ring in idle and unused kinds are ignored; clear writes 1 into every ring entry
// query: a ram walk over every entry, then three divisions in turn
// on one serial divider, then S_OUT registers the result and its strobe;
// the receiver cannot stall results
// reset starts a clear pass that writes 1 into every ring entry, busy high
module frame_time_statistics_core
  import ftstat_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 60
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  ftstat_in_t  item_i,
  output logic        result_valid_o,
  output ftstat_out_t result_o
);

  localparam int unsigned PW  = $clog2(HISTORY_DEPTH);
  localparam int unsigned TW  = $clog2(1000 * HISTORY_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(HISTORY_DEPTH - 1);
  localparam logic [TW-1:0] NUM  = TW'(1000 * HISTORY_DEPTH);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_DIV,
    S_OUT
  } state_e;

  state_e          state_q, state_d;
  logic [PW-1:0]   wp_q, wp_d;
  logic [PW-1:0]   clr_q, clr_d;
  logic [PW-1:0]   iss_q, iss_d;
  logic            iss_on_q, iss_on_d;
  logic            vld_q, vld_d;
  logic [PW-1:0]   idx_q, idx_d;
  logic [TW-1:0]   total_q, total_d;
  logic [MS_W-1:0] min_q, min_d;
  logic [MS_W-1:0] max_q, max_d;
  logic [MS_W-1:0] lat_q, lat_d;
  logic [1:0]      sel_q, sel_d;
  logic            act_q, act_d;
  logic [MS_W-1:0] avg_q, avg_d;
  logic [MS_W-1:0] fast_q, fast_d;
  logic [MS_W-1:0] slow_q, slow_d;
  logic            res_vld_q, res_vld_d;
  ftstat_out_t     res_q, res_d;

  logic            we;
  logic [PW-1:0]   waddr;
  logic [MS_W-1:0] wdata;
  logic            re;
  logic [MS_W-1:0] rdata;
  logic [PW-1:0]   lat_idx;
  logic [MS_W-1:0] sat_ms;
  logic            div_start;
  logic            div_done;
  logic [TW-1:0]   div_num;
  logic [TW-1:0]   div_den;
  logic [TW-1:0]   div_quo;
  logic            accept;

  assign accept  = start && (state_q == S_IDLE);
  assign busy    = (state_q != S_IDLE);
  assign lat_idx = (wp_q == '0) ? LAST : (wp_q - PW'(1));

  always_comb begin
    if (item_i.frame_ms == '0) begin
      sat_ms = MS_MIN;
    end else if (item_i.frame_ms > IN_MSW'(MS_MAX)) begin
      sat_ms = MS_MAX;
    end else begin
      sat_ms = item_i.frame_ms[MS_W-1:0];
    end
  end

  always_comb begin
    case (sel_q)
      2'd0: begin
        div_num = NUM;
        div_den = total_q;
      end
      2'd1: begin
        div_num = TW'(MS_MAX);
        div_den = TW'(min_q);
      end
      default: begin
        div_num = TW'(MS_MAX);
        div_den = TW'(max_q);
      end
    endcase
  end

  assign div_start = (state_q == S_DIV) && !act_q;
  assign re        = (state_q == S_WALK) && iss_on_q;

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    clr_d     = clr_q;
    iss_d     = iss_q;
    iss_on_d  = iss_on_q;
    vld_d     = 1'b0;
    idx_d     = idx_q;
    total_d   = total_q;
    min_d     = min_q;
    max_d     = max_q;
    lat_d     = lat_q;
    sel_d     = sel_q;
    act_d     = act_q;
    avg_d     = avg_q;
    fast_d    = fast_q;
    slow_d    = slow_q;
    res_vld_d = 1'b0;
    res_d     = res_q;
    we        = 1'b0;
    waddr     = wp_q;
    wdata     = sat_ms;
    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = MS_MIN;
        clr_d = clr_q + PW'(1);
        if (clr_q == LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (item_i.kind)
            KIND_RECORD: begin
              we   = 1'b1;
              wp_d = (wp_q == LAST) ? '0 : (wp_q + PW'(1));
            end
            KIND_CLEAR: begin
              wp_d    = '0;
              clr_d   = '0;
              state_d = S_CLEAR;
            end
            KIND_QUERY: begin
              iss_d    = '0;
              iss_on_d = 1'b1;
              total_d  = '0;
              min_d    = MS_MAX;
              max_d    = MS_MIN;
              state_d  = S_WALK;
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (iss_on_q) begin
          vld_d = 1'b1;
          idx_d = iss_q;
          if (iss_q == LAST) begin
            iss_on_d = 1'b0;
          end else begin
            iss_d = iss_q + PW'(1);
          end
        end
        if (vld_q) begin
          total_d = total_q + TW'(rdata);
          if (rdata < min_q) begin
            min_d = rdata;
          end
          if (rdata > max_q) begin
            max_d = rdata;
          end
          if (idx_q == lat_idx) begin
            lat_d = rdata;
          end
          if (idx_q == LAST) begin
            sel_d   = 2'd0;
            act_d   = 1'b0;
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_start) begin
          act_d = 1'b1;
        end else if (div_done) begin
          act_d = 1'b0;
          sel_d = sel_q + 2'd1;
          case (sel_q)
            2'd0:    avg_d  = div_quo[MS_W-1:0];
            2'd1:    fast_d = div_quo[MS_W-1:0];
            default: begin
              slow_d  = div_quo[MS_W-1:0];
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_OUT: begin
        res_vld_d        = 1'b1;
        res_d.avg_rate   = avg_q;
        res_d.best_gain  = (fast_q >= avg_q) ? (fast_q - avg_q) : '0;
        res_d.worst_loss = (avg_q >= slow_q) ? (avg_q - slow_q) : '0;
        res_d.latest_ms  = lat_q;
        state_d          = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      wp_q      <= '0;
      clr_q     <= '0;
      iss_on_q  <= 1'b0;
      vld_q     <= 1'b0;
      sel_q     <= '0;
      act_q     <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      clr_q     <= clr_d;
      iss_on_q  <= iss_on_d;
      vld_q     <= vld_d;
      sel_q     <= sel_d;
      act_q     <= act_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iss_q   <= iss_d;
    idx_q   <= idx_d;
    total_q <= total_d;
    min_q   <= min_d;
    max_q   <= max_d;
    lat_q   <= lat_d;
    avg_q   <= avg_d;
    fast_q  <= fast_d;
    slow_q  <= slow_d;
    res_q   <= res_d;
  end

  ftstat_ram #(
    .WIDTH(MS_W),
    .DEPTH(HISTORY_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(iss_q),
    .rdata_o(rdata)
  );

  ftstat_div #(
    .W(TW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_num),
    .divisor_i (div_den),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

>>> rtl/core/ftstat_chk.sv
// port level checks for the frame time statistics core and their binding
module ftstat_chk
  import ftstat_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input ftstat_in_t  item_i,
  input logic        result_valid_o,
  input ftstat_out_t result_o
);

  // a query is a long walk, so strobes never come back to back
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe lasted more than one cycle");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.kind == KIND_QUERY) |=> busy)
    else $error("query accepted without going busy");

  a_record_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.kind == KIND_RECORD) |=> !busy && !result_valid_o)
    else $error("record item stalled or produced a result");

  a_avg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.avg_rate >= MS_MIN) && (result_o.avg_rate <= MS_MAX)
      && (result_o.latest_ms >= MS_MIN) && (result_o.latest_ms <= MS_MAX))
    else $error("average rate or latest time out of range");

  a_spread_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.best_gain < MS_MAX) && (result_o.worst_loss < MS_MAX))
    else $error("rate spread out of range");

endmodule

bind frame_time_statistics_core ftstat_chk u_ftstat_chk (.*);

>>> bench/tb_frame_time_statistics_core.sv
// testbench of the frame time statistics core: directed and random items against a predictor
module tb_frame_time_statistics_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ftstat_pkg::*;

  localparam int unsigned DEPTH          = 60;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_TAIL     = 200;
  localparam logic [1:0]  KIND_UNUSED    = 2'd3;

  typedef enum int unsigned {
    SPAN_ANY,
    SPAN_FAST,
    SPAN_NEAR_MAX,
    SPAN_RAW,
    SPAN_CORNERS
  } ms_span_e;

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  ftstat_in_t  item_i = '0;
  logic        result_valid_o;
  ftstat_out_t result_o;

  logic [MS_W-1:0] ring_ms [DEPTH];
  int unsigned     ring_wpos;
  ftstat_out_t     expected_stats [$];

  int unsigned gap_max = 14;
  int unsigned items_sent = 0;
  int unsigned mismatch_count = 0;
  int unsigned stalled_cycles = 0;

  frame_time_statistics_core #(
    .HISTORY_DEPTH(DEPTH)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always #1 clk = ~clk;

  function automatic void ring_clear();
    for (int unsigned i = 0; i < DEPTH; i++) ring_ms[i] = MS_MIN;
    ring_wpos = 0;
  endfunction

  function automatic void ring_record(input logic [IN_MSW-1:0] ms);
    logic [MS_W-1:0] v;
    if (ms < MS_MIN) v = MS_MIN;
    else if (ms > MS_MAX) v = MS_MAX;
    else v = ms[MS_W-1:0];
    ring_ms[ring_wpos] = v;
    ring_wpos = (ring_wpos == DEPTH - 1) ? 0 : ring_wpos + 1;
  endfunction

  function automatic ftstat_out_t window_stats();
    int unsigned total, shortest, longest, avg, fast, slow, idx;
    ftstat_out_t r;
    total    = 0;
    shortest = MS_MAX;
    longest  = MS_MIN;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      total += ring_ms[i];
      if (ring_ms[i] < shortest) shortest = ring_ms[i];
      if (ring_ms[i] > longest) longest = ring_ms[i];
    end
    avg  = (int'(MS_MAX) * DEPTH) / total;
    fast = int'(MS_MAX) / shortest;
    slow = int'(MS_MAX) / longest;
    idx  = (ring_wpos == 0) ? DEPTH - 1 : ring_wpos - 1;
    r.avg_rate   = MS_W'(avg);
    r.best_gain  = MS_W'((fast >= avg) ? fast - avg : 0);
    r.worst_loss = MS_W'((avg >= slow) ? avg - slow : 0);
    r.latest_ms  = ring_ms[idx];
    return r;
  endfunction

  function automatic logic [IN_MSW-1:0] draw_frame_ms(input ms_span_e span);
    case (span)
      SPAN_ANY:      return IN_MSW'($urandom_range(1, 1000));
      SPAN_FAST:     return IN_MSW'($urandom_range(0, 12));
      SPAN_NEAR_MAX: return IN_MSW'($urandom_range(900, 1100));
      SPAN_RAW:      return IN_MSW'($urandom);
      default:       return $urandom_range(0, 1) ? '1 : IN_MSW'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic void flag(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void check_field(input string name, input logic [MS_W-1:0] want,
                                      input logic [MS_W-1:0] got);
    if (got !== want) flag($sformatf("%s expected %0d, got %0d", name, want, got));
  endfunction

  always @(posedge clk) begin
    ftstat_out_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_stats.size() == 0) begin
        flag($sformatf("result with nothing expected: avg_rate %0d best_gain %0d",
                       result_o.avg_rate, result_o.best_gain));
      end else begin
        want = expected_stats.pop_front();
        check_field("avg_rate", want.avg_rate, result_o.avg_rate);
        check_field("best_gain", want.best_gain, result_o.best_gain);
        check_field("worst_loss", want.worst_loss, result_o.worst_loss);
        check_field("latest_ms", want.latest_ms, result_o.latest_ms);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [1:0] kind, input logic [IN_MSW-1:0] ms);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    @(negedge clk);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_i = '{kind: kind, frame_ms: ms};
    start  = 1'b1;
    do @(posedge clk); while (busy);
    case (kind)
      KIND_RECORD: ring_record(ms);
      KIND_CLEAR:  ring_clear();
      KIND_QUERY:  expected_stats.push_back(window_stats());
      default: ;
    endcase
    if (kind != KIND_UNUSED) items_sent++;
  endtask

  task automatic pause_sender();
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_stats.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_and_saturation();
    gap_max = 14;
    send_item(KIND_QUERY, '0);
    send_item(KIND_RECORD, 16'd0);
    send_item(KIND_QUERY, '1);
    send_item(KIND_RECORD, 16'd1000);
    send_item(KIND_RECORD, 16'd1001);
    send_item(KIND_QUERY, '0);
    send_item(KIND_RECORD, 16'hFFFF);
    send_item(KIND_RECORD, 16'd500);
    send_item(KIND_UNUSED, 16'hFFFF);
    send_item(KIND_QUERY, '0);
    send_item(KIND_CLEAR, 16'hFFFF);
    send_item(KIND_QUERY, '0);
    send_item(KIND_RECORD, 16'd1);
    send_item(KIND_QUERY, '0);
    send_item(KIND_QUERY, '0);
    send_item(KIND_RECORD, 16'd999);
    send_item(KIND_CLEAR, '0);
    send_item(KIND_QUERY, '0);
  endtask

  task automatic test_full_window();
    gap_max = 0;
    repeat (DEPTH) send_item(KIND_RECORD, IN_MSW'($urandom_range(1000, 65535)));
    send_item(KIND_QUERY, '0);
    gap_max = 14;
    repeat (DEPTH + 7) send_item(KIND_RECORD, IN_MSW'($urandom_range(1, 1000)));
    send_item(KIND_QUERY, '0);
    send_item(KIND_CLEAR, '0);
    repeat (DEPTH - 1) send_item(KIND_RECORD, 16'd1);
    send_item(KIND_RECORD, 16'd1000);
    send_item(KIND_QUERY, '0);
  endtask

  task automatic test_drain_pause();
    gap_max = 3;
    send_item(KIND_RECORD, draw_frame_ms(SPAN_ANY));
    send_item(KIND_QUERY, '0);
    send_item(KIND_QUERY, '0);
    pause_sender();
    wait_drained();
    send_item(KIND_QUERY, '0);
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned stop_at, burst_len, pick;
    ms_span_e    span;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
      if ($urandom_range(0, 9) < 7) begin
        // record burst closed by a query
        span = ms_span_e'($urandom_range(0, 4));
        burst_len = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90) : $urandom_range(0, 16);
        repeat (burst_len) send_item(KIND_RECORD, draw_frame_ms(span));
        send_item(KIND_QUERY, IN_MSW'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          pick = $urandom_range(0, 9);
          if (pick < 2) send_item(KIND_CLEAR, IN_MSW'($urandom));
          else if (pick < 4) send_item(KIND_UNUSED, IN_MSW'($urandom));
          else if (pick < 7) send_item(KIND_QUERY, IN_MSW'($urandom));
          else send_item(KIND_RECORD, IN_MSW'($urandom));
        end
      end
    end
  endtask

  initial begin
    ring_clear();
    rst_ni = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    test_reset_and_saturation();
    test_full_window();
    test_random_traffic(400);
    test_drain_pause();
    test_random_traffic(440);

    pause_sender();
    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatch_count == 0 && expected_stats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/ftstat_pkg.sv
rtl/core/ftstat_ram.sv
rtl/core/ftstat_div.sv
rtl/core/frame_time_statistics_core.sv
rtl/core/ftstat_chk.sv
bench/tb_frame_time_statistics_core.sv
